// ===== rtl/czs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// czs_pkg
// Shared widths, register indexes and the zoom factor clamp for the crop and
// zoom scan address generator.
// ----------------------------------------------------------------------------
package czs_pkg;

    // offset arithmetic wraps at this width
    localparam int OFFSET_BITS = 32;
    // largest zoom factor honoured, larger values saturate
    localparam int MAX_ZOOM    = 16;

    // register field widths
    localparam int DIM_W   = 16;
    localparam int ZOOM_W  = 5;
    localparam int LINE_W  = DIM_W + 1;
    localparam int LEND_W  = DIM_W + 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // stream widths
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = ((OFFSET_BITS + 7) / 8) * 8;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH    = 3'd0,
        REG_START_LINE     = 3'd1,
        REG_START_SAMPLE   = 3'd2,
        REG_WINDOW_LINES   = 3'd3,
        REG_WINDOW_SAMPLES = 3'd4,
        REG_REPLICATE_MODE = 3'd5,
        REG_ZOOM_FACTOR    = 3'd6
    } czs_reg_t;

    // zero counts as one, anything above the maximum saturates
    function automatic logic [ZOOM_W-1:0] eff_factor(input logic [ZOOM_W-1:0] z);
        logic [ZOOM_W-1:0] f;
        f = z;
        if (z == '0) begin
            f = ZOOM_W'(1);
        end else if (z > ZOOM_W'(MAX_ZOOM)) begin
            f = ZOOM_W'(MAX_ZOOM);
        end
        return f;
    endfunction

endpackage

// ===== rtl/crop_zoom_scan_address_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crop_zoom_scan_address_gen
// Source pixel offset generator for a cropped, nearest-neighbour zoomed scan.
// ----------------------------------------------------------------------------
// Every accepted item yields one result: the offset of the source pixel for
// the next output pixel, line*image_width + start_sample + sample, with the
// first line one past start_line to step over the label line. Decimate mode
// steps lines and samples by the zoom factor, replicate mode sends each sample
// and each line factor times. line_last travels as m_tlast and frame_last as
// m_tuser; after the last pixel of a frame the scan starts a new frame, and a
// restart item starts one at once. One item is taken every clock cycle while
// the output is not stalled, and the result shows on the output in the cycle
// after acceptance; the output register takes a new item while the previous
// result is being taken. The products for the frame start and the line step
// are formed when a register is written, so the per-item path is one
// three-input 32-bit add and the end compares.
module crop_zoom_scan_address_gen (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [czs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [czs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [czs_pkg::S_DATA_W-1:0]  s_tdata,   // [0] restart, rest zero
    // result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [czs_pkg::M_DATA_W-1:0]  m_tdata,   // [31:0] source_offset
    output logic                          m_tlast,   // line_last
    output logic                          m_tuser    // [0] frame_last
);
    import czs_pkg::*;

    // configuration registers
    logic [DIM_W-1:0]       image_width_reg, image_width_next;
    logic [DIM_W-1:0]       start_line_reg, start_line_next;
    logic [DIM_W-1:0]       start_sample_reg, start_sample_next;
    logic [DIM_W-1:0]       window_lines_reg, window_lines_next;
    logic [DIM_W-1:0]       window_samples_reg, window_samples_next;
    logic                   replicate_mode_reg, replicate_mode_next;
    logic [ZOOM_W-1:0]      zoom_factor_reg, zoom_factor_next;

    // values derived from the configuration
    logic [OFFSET_BITS-1:0] frame_base_reg, frame_base_next;
    logic [OFFSET_BITS-1:0] line_step_reg, line_step_next;
    logic [ZOOM_W-1:0]      inc_reg, inc_next;
    logic [ZOOM_W-1:0]      reps_reg, reps_next;
    logic [LEND_W-1:0]      line_end_reg, line_end_next;
    logic [ZOOM_W-1:0]      factor;
    logic [LINE_W-1:0]      first_line_next;

    // scan position
    logic [LINE_W-1:0]      line_index_reg, line_index_next;
    logic [ZOOM_W-1:0]      line_rep_reg, line_rep_next;
    logic [DIM_W-1:0]       sample_index_reg, sample_index_next;
    logic [ZOOM_W-1:0]      sample_rep_reg, sample_rep_next;
    logic [OFFSET_BITS-1:0] line_base_reg, line_base_next;
    logic                   frame_active_reg, frame_active_next;

    // output register
    logic                   m_valid_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic                   line_last_reg;
    logic                   frame_last_reg;

    // per item logic
    logic                   s_accept;
    logic                   load;
    logic [LINE_W-1:0]      cur_line;
    logic [ZOOM_W-1:0]      cur_line_rep;
    logic [DIM_W-1:0]       cur_sample;
    logic [ZOOM_W-1:0]      cur_sample_rep;
    logic [OFFSET_BITS-1:0] cur_base;
    logic [OFFSET_BITS-1:0] offset;
    logic                   sample_done;
    logic                   line_rep_done;
    logic                   line_done;
    logic                   frame_done;
    logic [DIM_W:0]         sample_sum;
    logic [LEND_W-1:0]      line_sum;

    // register write decode
    always_comb begin
        image_width_next    = image_width_reg;
        start_line_next     = start_line_reg;
        start_sample_next   = start_sample_reg;
        window_lines_next   = window_lines_reg;
        window_samples_next = window_samples_reg;
        replicate_mode_next = replicate_mode_reg;
        zoom_factor_next    = zoom_factor_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:    image_width_next    = cfg_wdata[DIM_W-1:0];
                REG_START_LINE:     start_line_next     = cfg_wdata[DIM_W-1:0];
                REG_START_SAMPLE:   start_sample_next   = cfg_wdata[DIM_W-1:0];
                REG_WINDOW_LINES:   window_lines_next   = cfg_wdata[DIM_W-1:0];
                REG_WINDOW_SAMPLES: window_samples_next = cfg_wdata[DIM_W-1:0];
                REG_REPLICATE_MODE: replicate_mode_next = cfg_wdata[0];
                REG_ZOOM_FACTOR:    zoom_factor_next    = cfg_wdata[ZOOM_W-1:0];
                default: ;
            endcase
        end
    end

    // derived values from the registers as they will stand after this edge
    always_comb begin
        factor          = eff_factor(zoom_factor_next);
        inc_next        = replicate_mode_next ? ZOOM_W'(1) : factor;
        reps_next       = replicate_mode_next ? factor : ZOOM_W'(1);
        first_line_next = LINE_W'(start_line_next) + LINE_W'(1);
        frame_base_next = OFFSET_BITS'(first_line_next * image_width_next);
        line_step_next  = OFFSET_BITS'(inc_next * image_width_next);
        line_end_next   = LEND_W'(first_line_next) + LEND_W'(window_lines_next);
    end

    // configuration and derived registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg    <= DIM_W'(1);
            start_line_reg     <= '0;
            start_sample_reg   <= '0;
            window_lines_reg   <= DIM_W'(1);
            window_samples_reg <= DIM_W'(1);
            replicate_mode_reg <= 1'b0;
            zoom_factor_reg    <= ZOOM_W'(1);
            frame_base_reg     <= OFFSET_BITS'(1);
            line_step_reg      <= OFFSET_BITS'(1);
            inc_reg            <= ZOOM_W'(1);
            reps_reg           <= ZOOM_W'(1);
            line_end_reg       <= LEND_W'(2);
        end else begin
            image_width_reg    <= image_width_next;
            start_line_reg     <= start_line_next;
            start_sample_reg   <= start_sample_next;
            window_lines_reg   <= window_lines_next;
            window_samples_reg <= window_samples_next;
            replicate_mode_reg <= replicate_mode_next;
            zoom_factor_reg    <= zoom_factor_next;
            frame_base_reg     <= frame_base_next;
            line_step_reg      <= line_step_next;
            inc_reg            <= inc_next;
            reps_reg           <= reps_next;
            line_end_reg       <= line_end_next;
        end
    end

    // handshake: take an item whenever the output register is free or draining
    assign s_accept = s_tvalid && s_tready;
    assign s_tready = !m_valid_reg || m_tready;

    // position in force for this item, reloaded at frame start
    always_comb begin
        load           = s_tdata[0] || !frame_active_reg;
        cur_line       = load ? (LINE_W'(start_line_reg) + LINE_W'(1)) : line_index_reg;
        cur_line_rep   = load ? '0 : line_rep_reg;
        cur_sample     = load ? '0 : sample_index_reg;
        cur_sample_rep = load ? '0 : sample_rep_reg;
        cur_base       = load ? frame_base_reg : line_base_reg;
    end

    // offset and end tests
    always_comb begin
        offset        = cur_base + OFFSET_BITS'(start_sample_reg) + OFFSET_BITS'(cur_sample);
        sample_sum    = (DIM_W+1)'(cur_sample) + (DIM_W+1)'(inc_reg);
        line_sum      = LEND_W'(cur_line) + LEND_W'(inc_reg);
        sample_done   = ({1'b0, cur_sample_rep} + (ZOOM_W+1)'(1)) >= {1'b0, reps_reg};
        line_rep_done = ({1'b0, cur_line_rep} + (ZOOM_W+1)'(1)) >= {1'b0, reps_reg};
        line_done     = sample_done && (sample_sum >= (DIM_W+1)'(window_samples_reg));
        frame_done    = line_done && line_rep_done && (line_sum >= line_end_reg);
    end

    // next scan position
    always_comb begin
        line_index_next   = cur_line;
        line_rep_next     = cur_line_rep;
        sample_index_next = cur_sample;
        sample_rep_next   = cur_sample_rep;
        line_base_next    = cur_base;
        frame_active_next = 1'b1;
        priority if (frame_done) begin
            frame_active_next = 1'b0;
        end else if (line_done) begin
            sample_index_next = '0;
            sample_rep_next   = '0;
            if (line_rep_done) begin
                line_rep_next   = '0;
                line_index_next = line_sum[LINE_W-1:0];
                line_base_next  = cur_base + line_step_reg;
            end else begin
                line_rep_next = cur_line_rep + ZOOM_W'(1);
            end
        end else if (sample_done) begin
            sample_rep_next   = '0;
            sample_index_next = sample_sum[DIM_W-1:0];
        end else begin
            sample_rep_next = cur_sample_rep + ZOOM_W'(1);
        end
    end

    // scan state, advanced on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_index_reg   <= LINE_W'(1);
            line_rep_reg     <= '0;
            sample_index_reg <= '0;
            sample_rep_reg   <= '0;
            line_base_reg    <= '0;
            frame_active_reg <= 1'b0;
        end else if (s_accept) begin
            line_index_reg   <= line_index_next;
            line_rep_reg     <= line_rep_next;
            sample_index_reg <= sample_index_next;
            sample_rep_reg   <= sample_rep_next;
            line_base_reg    <= line_base_next;
            frame_active_reg <= frame_active_next;
        end
    end

    // output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            offset_reg     <= offset;
            line_last_reg  <= line_done;
            frame_last_reg <= frame_done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(offset_reg);
    assign m_tlast  = line_last_reg;
    assign m_tuser  = frame_last_reg;

`ifndef SYNTH
    // the last pixel of a frame always closes an output line
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast || !m_tuser))
        else $error("frame_last without line_last");

    // an accepted item always leaves a result waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("accepted item produced no result");

    // the frame closes after its last pixel is sent
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && frame_done) |=> !frame_active_reg)
        else $error("frame still active after last pixel");

    // an unaccepted item leaves the scan position alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> ($stable(sample_index_reg) && $stable(line_base_reg)))
        else $error("scan position moved without an item");
`endif

endmodule

// ===== verif/tb_crop_zoom_scan_address_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crop_zoom_scan_address_gen
// Self-checking bench for the crop and zoom scan address generator.
// ----------------------------------------------------------------------------
// A short table of directed items comes first. It covers the register values
// after reset, the largest offsets with their wrap past 32 bits, both scan
// modes, a zoom of zero, a saturated zoom, an empty window and restart items.
// Random phases follow, each with fresh register values and a burst of items.
// An item-level scan model tracks every accepted item and predicts the offset
// and the line and frame flags. Each result is compared with the oldest
// prediction. Both sides of the stream stall at random, except in one calm
// phase.
module tb_crop_zoom_scan_address_gen;
    import czs_pkg::*;

    localparam int  CLK_PERIOD   = 8;
    localparam int  RESET_CYCLES = 8;
    localparam int  RANDOM_ITEMS = 500;
    localparam int  IDLE_PCT     = 35;
    localparam int  TAIL_CYCLES  = 8;
    // index past the last register, the block ignores writes to it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [31:0] offset;
        logic        line_last;
        logic        frame_last;
    } scan_result_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_SCAN,
        ROW_PINNED
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] wdata;
        logic                  restart;
        scan_result_t          known;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    // value typed into the table for the item now offered
    logic                  item_pinned;
    scan_result_t          item_pin;

    logic                  src_gaps;
    logic                  sink_gaps;
    int unsigned           mismatch_count;
    scan_result_t          pending_scan_q[$];
    dir_row_t              dir_rows[$];

    // model copy of the registers
    logic [15:0] cfg_width;
    logic [15:0] cfg_start_line;
    logic [15:0] cfg_start_sample;
    logic [15:0] cfg_win_lines;
    logic [15:0] cfg_win_samples;
    logic        cfg_replicate;
    logic [4:0]  cfg_zoom;

    // model copy of the scan position
    logic [16:0] scan_line;
    logic [4:0]  line_rep;
    logic [15:0] scan_sample;
    logic [4:0]  sample_rep;
    logic [31:0] line_base;
    logic        in_frame;

    crop_zoom_scan_address_gen dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [0] restart, rest zero
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [31:0] source_offset
        .m_tlast   (m_tlast),     // line_last
        .m_tuser   (m_tuser)      // [0] frame_last
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // scan model: one step per accepted item
    task automatic predict_scan(input logic restart, output scan_result_t res);
        int unsigned factor;
        int unsigned reps;
        int unsigned inc;
        int unsigned line_end;
        logic        smp_done;
        logic        ln_done;
        logic        frm_done;
        if (restart || !in_frame) begin
            scan_line   = 17'(32'(cfg_start_line) + 32'd1);
            line_rep    = '0;
            scan_sample = '0;
            sample_rep  = '0;
            line_base   = 32'(64'(scan_line) * 64'(cfg_width));
            in_frame    = 1'b1;
        end
        // zero counts as one, large factors saturate
        factor = 32'(cfg_zoom);
        if (factor == 0) begin
            factor = 1;
        end else if (factor > MAX_ZOOM) begin
            factor = MAX_ZOOM;
        end
        reps = cfg_replicate ? factor : 1;
        inc  = cfg_replicate ? 1 : factor;

        res.offset = line_base + 32'(cfg_start_sample) + 32'(scan_sample);
        smp_done = (32'(sample_rep) + 1 >= reps);
        ln_done  = smp_done && (32'(scan_sample) + inc >= 32'(cfg_win_samples));
        line_end = 32'(cfg_start_line) + 1 + 32'(cfg_win_lines);
        frm_done = ln_done && (32'(line_rep) + 1 >= reps) &&
                   (32'(scan_line) + inc >= line_end);
        res.line_last  = ln_done;
        res.frame_last = frm_done;

        // advance to the pixel of the next item
        if (frm_done) begin
            in_frame = 1'b0;
        end else if (ln_done) begin
            scan_sample = '0;
            sample_rep  = '0;
            if (32'(line_rep) + 1 >= reps) begin
                line_rep  = '0;
                scan_line = 17'(32'(scan_line) + inc);
                line_base = line_base + 32'(64'(inc) * 64'(cfg_width));
            end else begin
                line_rep = line_rep + 5'd1;
            end
        end else if (smp_done) begin
            sample_rep  = '0;
            scan_sample = 16'(32'(scan_sample) + inc);
        end else begin
            sample_rep = sample_rep + 5'd1;
        end
    endtask

    // register writes, item acceptance and result checking
    always @(posedge aclk) begin
        scan_result_t want;
        scan_result_t got;
        if (!aresetn) begin
            cfg_width        = 16'd1;
            cfg_start_line   = '0;
            cfg_start_sample = '0;
            cfg_win_lines    = 16'd1;
            cfg_win_samples  = 16'd1;
            cfg_replicate    = 1'b0;
            cfg_zoom         = 5'd1;
            scan_line        = 17'd1;
            line_rep         = '0;
            scan_sample      = '0;
            sample_rep       = '0;
            line_base        = '0;
            in_frame         = 1'b0;
        end else begin
            // result side
            if (m_tvalid && m_tready) begin
                got = '{offset: m_tdata[31:0], line_last: m_tlast, frame_last: m_tuser};
                if (pending_scan_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual offset %h last %b/%b",
                             $time, got.offset, got.line_last, got.frame_last);
                end else begin
                    want = pending_scan_q.pop_front();
                    if (got.offset !== want.offset) begin
                        mismatch_count++;
                        $display("%0t: source_offset expected %h actual %h",
                                 $time, want.offset, got.offset);
                    end
                    if (got.line_last !== want.line_last) begin
                        mismatch_count++;
                        $display("%0t: line_last expected %b actual %b",
                                 $time, want.line_last, got.line_last);
                    end
                    if (got.frame_last !== want.frame_last) begin
                        mismatch_count++;
                        $display("%0t: frame_last expected %b actual %b",
                                 $time, want.frame_last, got.frame_last);
                    end
                end
            end
            // register writes
            if (cfg_we) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:    cfg_width        = cfg_wdata;
                    REG_START_LINE:     cfg_start_line   = cfg_wdata;
                    REG_START_SAMPLE:   cfg_start_sample = cfg_wdata;
                    REG_WINDOW_LINES:   cfg_win_lines    = cfg_wdata;
                    REG_WINDOW_SAMPLES: cfg_win_samples  = cfg_wdata;
                    REG_REPLICATE_MODE: cfg_replicate    = cfg_wdata[0];
                    REG_ZOOM_FACTOR:    cfg_zoom         = cfg_wdata[4:0];
                    default: ;
                endcase
            end
            // input side
            if (s_tvalid && s_tready) begin
                predict_scan(s_tdata[0], want);
                pending_scan_q.push_back(item_pinned ? item_pin : want);
            end
        end
    end

    // result side backpressure
    always @(negedge aclk) begin
        m_tready <= !sink_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_scan_q.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // valid stays high between back-to-back items, it drops only in a gap
    task automatic send_item(input logic restart, input logic pinned,
                             input scan_result_t pin);
        @(negedge aclk);
        while (src_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= {{(S_DATA_W - 1){1'b0}}, restart};
        item_pinned <= pinned;
        item_pin    <= pin;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic dir_row_t row_write(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        return '{kind: ROW_WRITE, reg_idx: idx, wdata: val, restart: 1'b0, known: '0};
    endfunction

    function automatic dir_row_t row_scan(input logic restart);
        return '{kind: ROW_SCAN, reg_idx: '0, wdata: '0, restart: restart, known: '0};
    endfunction

    function automatic dir_row_t row_pinned(input logic restart, input logic [31:0] off,
                                            input logic ll, input logic fl);
        return '{kind: ROW_PINNED, reg_idx: '0, wdata: '0, restart: restart,
                 known: '{offset: off, line_last: ll, frame_last: fl}};
    endfunction

    // mostly small sizes, now and then an extreme or a full random value
    function automatic logic [15:0] pick_dim(input int unsigned small_hi);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return 16'hFFFF;
        end else if (r == 1) begin
            return 16'h0000;
        end else if (r == 2) begin
            return 16'($urandom);
        end
        return 16'($urandom_range(1, small_hi));
    endfunction

    // generous fixed limit
    initial begin
        #(CLK_PERIOD * 250000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int unsigned sent;
        int unsigned phase_no;
        int unsigned burst;
        logic [15:0] junk;

        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        item_pinned    = 1'b0;
        item_pin       = '0;
        src_gaps       = 1'b1;
        sink_gaps      = 1'b1;
        mismatch_count = 0;

        // directed table
        // register values after reset: one-pixel window on line one
        dir_rows.push_back(row_pinned(1'b0, 32'h0000_0001, 1'b1, 1'b1));
        dir_rows.push_back(row_pinned(1'b1, 32'h0000_0001, 1'b1, 1'b1));
        // largest stride and start, the offset lands on all ones
        dir_rows.push_back(row_write(REG_IMAGE_WIDTH, 16'hFFFF));
        dir_rows.push_back(row_write(REG_START_LINE, 16'hFFFF));
        dir_rows.push_back(row_write(REG_START_SAMPLE, 16'hFFFF));
        dir_rows.push_back(row_pinned(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1));
        // second sample wraps the offset past 32 bits
        dir_rows.push_back(row_write(REG_WINDOW_SAMPLES, 16'd2));
        dir_rows.push_back(row_pinned(1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0));
        dir_rows.push_back(row_pinned(1'b0, 32'h0000_0000, 1'b1, 1'b1));
        // replicate by two over a small window, restart part way
        dir_rows.push_back(row_write(REG_IMAGE_WIDTH, 16'd10));
        dir_rows.push_back(row_write(REG_START_LINE, 16'd2));
        dir_rows.push_back(row_write(REG_START_SAMPLE, 16'd3));
        dir_rows.push_back(row_write(REG_WINDOW_LINES, 16'd3));
        dir_rows.push_back(row_write(REG_WINDOW_SAMPLES, 16'd4));
        dir_rows.push_back(row_write(REG_REPLICATE_MODE, 16'd1));
        dir_rows.push_back(row_write(REG_ZOOM_FACTOR, 16'd2));
        for (int i = 0; i < 6; i++) dir_rows.push_back(row_scan(1'b0));
        dir_rows.push_back(row_scan(1'b1));
        dir_rows.push_back(row_scan(1'b0));
        dir_rows.push_back(row_scan(1'b0));
        // zoom of zero acts as one
        dir_rows.push_back(row_write(REG_REPLICATE_MODE, 16'd0));
        dir_rows.push_back(row_write(REG_ZOOM_FACTOR, 16'd0));
        dir_rows.push_back(row_scan(1'b0));
        dir_rows.push_back(row_scan(1'b1));
        // zoom above the maximum saturates, write to the unused index
        dir_rows.push_back(row_write(REG_ZOOM_FACTOR, 16'd31));
        dir_rows.push_back(row_write(REG_WINDOW_LINES, 16'd40));
        dir_rows.push_back(row_write(REG_WINDOW_SAMPLES, 16'd40));
        dir_rows.push_back(row_write(REG_UNUSED, 16'hFFFF));
        for (int i = 0; i < 3; i++) dir_rows.push_back(row_scan(1'b0));
        // empty window acts as one pixel
        dir_rows.push_back(row_write(REG_WINDOW_LINES, 16'd0));
        dir_rows.push_back(row_write(REG_WINDOW_SAMPLES, 16'd0));
        dir_rows.push_back(row_scan(1'b0));
        dir_rows.push_back(row_scan(1'b0));
        // largest window, replicate at the maximum zoom
        dir_rows.push_back(row_write(REG_WINDOW_LINES, 16'hFFFF));
        dir_rows.push_back(row_write(REG_WINDOW_SAMPLES, 16'hFFFF));
        dir_rows.push_back(row_scan(1'b1));
        dir_rows.push_back(row_scan(1'b0));
        dir_rows.push_back(row_write(REG_REPLICATE_MODE, 16'd1));
        dir_rows.push_back(row_write(REG_ZOOM_FACTOR, 16'd16));
        dir_rows.push_back(row_scan(1'b0));
        dir_rows.push_back(row_scan(1'b0));

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_WRITE:  write_reg(dir_rows[i].reg_idx, dir_rows[i].wdata);
                ROW_SCAN:   send_item(dir_rows[i].restart, 1'b0, '0);
                ROW_PINNED: send_item(dir_rows[i].restart, 1'b1, dir_rows[i].known);
                default: ;
            endcase
        end
        wait_drained();

        // random phases, registers rewritten only once the results are in
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 1)) write_reg(REG_IMAGE_WIDTH, pick_dim(40));
            if ($urandom_range(0, 1)) write_reg(REG_START_LINE, pick_dim(20));
            if ($urandom_range(0, 1)) write_reg(REG_START_SAMPLE, pick_dim(20));
            if ($urandom_range(0, 1)) write_reg(REG_WINDOW_LINES, pick_dim(6));
            if ($urandom_range(0, 1)) write_reg(REG_WINDOW_SAMPLES, pick_dim(8));
            // upper data bits are don't-care for the narrow registers
            junk = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000;
            if ($urandom_range(0, 1)) begin
                write_reg(REG_REPLICATE_MODE, {junk[15:1], 1'($urandom_range(0, 1))});
            end
            if ($urandom_range(0, 1)) begin
                write_reg(REG_ZOOM_FACTOR,
                          {junk[15:5], ($urandom_range(0, 3) == 0) ?
                           5'($urandom_range(0, 31)) : 5'($urandom_range(1, 4))});
            end
            if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, 16'($urandom));

            // one long stretch with neither side stalling
            src_gaps  = (phase_no != 2);
            sink_gaps = (phase_no != 2);
            burst     = (phase_no == 2) ? 80 : $urandom_range(10, 50);
            repeat (burst) begin
                send_item($urandom_range(0, 24) == 0, 1'b0, '0);
                sent++;
            end
            wait_drained();
            phase_no++;
        end

        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_scan_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
